// ----- src/mprs_pkg.sv -----
// Shared types and constants of the masked Poisson relaxation solver.
`timescale 1ns / 1ps
package mprs_pkg;

   // item opcodes carried in req_tuser
   localparam logic [1:0] OP_LOAD = 2'd0;
   localparam logic [1:0] OP_RUN  = 2'd1;
   localparam logic [1:0] OP_READ = 2'd2;

   // configuration register indexes
   localparam logic [2:0] CSR_WIDTH     = 3'd0;
   localparam logic [2:0] CSR_HEIGHT    = 3'd1;
   localparam logic [2:0] CSR_ITER      = 3'd2;
   localparam logic [2:0] CSR_INTERVAL  = 3'd3;
   localparam logic [2:0] CSR_THRESHOLD = 3'd4;

   localparam int FIELD_BITS   = 24;
   localparam int ERR_BITS     = 48;
   localparam int SWEEP_BITS   = 17;
   localparam int CSR_IDX_BITS = 3;
   localparam int CSR_DAT_BITS = 24;
   localparam int REQ_DAT_BITS = 168;
   localparam int RSP_DAT_BITS = 192;

   // control of the stencil unit
   typedef struct packed {
      logic load_ctr;
      logic add_nb;
   } alu_ctl_type;

endpackage

// ----- src/mprs_store.sv -----
// Pixel store: value, guidance term and mask memories with one registered read port.
`timescale 1ns / 1ps
module mprs_store #(
   parameter int AW = 16,
   parameter int VB = 24
) (
   input  logic              clock,
   input  logic              tgt_we,
   input  logic              aux_we,
   input  logic [AW-1:0]     wr_addr,
   input  logic [3*VB-1:0]   wr_tgt,
   input  logic [3*VB-1:0]   wr_grad,
   input  logic              wr_mask,
   input  logic [AW-1:0]     rd_addr,
   output logic [3*VB-1:0]   rd_val,
   output logic [3*VB-1:0]   rd_grad,
   output logic              rd_mask
);
   localparam int DEPTH = 1 << AW;

   logic [3*VB-1:0] tgt_mem [DEPTH];
   logic [3*VB-1:0] grad_mem [DEPTH];
   logic            mask_mem [DEPTH];

   // write value store
   always_ff @(posedge clock) begin
      if (tgt_we) begin
         tgt_mem[wr_addr] <= wr_tgt;
      end
      rd_val <= tgt_mem[rd_addr];
   end

   // write guidance and mask on loads
   always_ff @(posedge clock) begin
      if (aux_we) begin
         grad_mem[wr_addr] <= wr_grad;
         mask_mem[wr_addr] <= wr_mask;
      end
      rd_grad <= grad_mem[rd_addr];
      rd_mask <= mask_mem[rd_addr];
   end

endmodule

// ----- src/mprs_alu.sv -----
// Stencil unit: accumulates the five-point sum and forms update and residual.
`timescale 1ns / 1ps
module mprs_alu #(
   parameter int VB = 24
) (
   input  logic                    clock,
   input  mprs_pkg::alu_ctl_type   ctl,
   input  logic [3*VB-1:0]         rd_val,
   input  logic [3*VB-1:0]         rd_grad,
   output logic [3*VB-1:0]         upd,
   output logic [3*(VB+3)-1:0]     res
);
   import mprs_pkg::*;

   localparam int AB = VB + 3;
   localparam logic signed [AB-1:0] VMAX = AB'((1 << (VB - 1)) - 1);
   localparam logic signed [AB-1:0] VMIN = -VMAX - AB'(1);

   logic signed [AB-1:0] acc_ff [3];
   logic signed [VB-1:0] ctr_ff [3];

   // load center, then add neighbors
   always_ff @(posedge clock) begin
      for (int ch = 0; ch < 3; ch++) begin
         if (ctl.load_ctr) begin
            acc_ff[ch] <= AB'($signed(rd_grad[ch*VB +: VB]));
            ctr_ff[ch] <= $signed(rd_val[ch*VB +: VB]);
         end else if (ctl.add_nb) begin
            acc_ff[ch] <= acc_ff[ch] + AB'($signed(rd_val[ch*VB +: VB]));
         end
      end
   end

   // floor quarter with saturation, and absolute residual
   always_comb begin
      logic signed [AB-1:0] q;
      logic signed [AB:0]   d;
      for (int ch = 0; ch < 3; ch++) begin
         q = acc_ff[ch] >>> 2;
         if (q > VMAX) begin
            upd[ch*VB +: VB] = VMAX[VB-1:0];
         end else if (q < VMIN) begin
            upd[ch*VB +: VB] = VMIN[VB-1:0];
         end else begin
            upd[ch*VB +: VB] = q[VB-1:0];
         end
         d = (AB+1)'(acc_ff[ch]) - ((AB+1)'(ctr_ff[ch]) <<< 2);
         if (d[AB]) begin
            d = -d;
         end
         res[ch*AB +: AB] = d[AB-1:0];
      end
   end

endmodule

// ----- src/masked_poisson_relaxation_solver_core.sv -----
// Top level of the masked Poisson relaxation solver: sequencer, registers and result stage.
//
// Items arrive on the req_ stream: req_tuser carries the opcode (load, run, read),
// req_tdata the pixel index, mask bit, target and guidance terms. Every item gives
// exactly one result beat on the rsp_ stream. Configuration goes in through the
// csr_ write channel, which is always ready, and is to be written only while idle; the block
// itself does not enforce this. A load or no-operation item is answered from the idle state,
// and a read passes through a read state first, since the pixel store has one registered
// read port. A run walks the interior of the image in raster order through the same port,
// pass by pass: a masked interior pixel steps through its centre read, four neighbour reads
// and the update, and an unmasked one ends once its mask is read. Each group of sweeps is
// followed by one residual pass of the same length when the threshold is set, and one final
// pass ends the run. The item channel is not ready during this work. The result waits in an
// output register; while the receiver stalls it holds, and the next item is taken once that
// beat leaves. Reset clears the control state and loads the register defaults; the pixel
// store is not cleared and holds nothing meaningful until loaded.
`timescale 1ns / 1ps
module masked_poisson_relaxation_solver_core #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256,
   parameter int VALUE_BITS = 24
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // pixel_index, in_mask, target_r, target_g, target_b, gradient_r, gradient_g, gradient_b
   input  logic [mprs_pkg::REQ_DAT_BITS-1:0]   req_tdata,
   // opcode
   input  logic [1:0]                          req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // pixel_r, pixel_g, pixel_b, error_r, error_g, error_b, converged, sweeps_done
   output logic [mprs_pkg::RSP_DAT_BITS-1:0]   rsp_tdata,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [mprs_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  logic [mprs_pkg::CSR_DAT_BITS-1:0]   csr_data
);
   import mprs_pkg::*;

   localparam int VB = VALUE_BITS;
   localparam int AW = $clog2(MAX_WIDTH * MAX_HEIGHT);
   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int HW = $clog2(MAX_HEIGHT + 1);
   localparam int RW = VB + 3;
   localparam int TW = FIELD_BITS + AW + 1;
   localparam int CW = (TW + 2 > ERR_BITS + 2) ? TW + 2 : ERR_BITS + 2;
   localparam logic signed [32:0] VMAX = (33'sd1 <<< (VB - 1)) - 33'sd1;
   localparam logic signed [32:0] VMIN = -VMAX - 33'sd1;
   localparam logic [ERR_BITS-1:0] ERR_MAX = '1;

   typedef enum logic [3:0] {
      ST_IDLE, ST_READ, ST_RUN_CHECK, ST_PASS_START, ST_PIX, ST_PASS_END,
      ST_CMP_SUM, ST_CMP_TEST, ST_OUT
   } state_type;

   typedef enum logic [1:0] {PASS_SWEEP, PASS_CHECK, PASS_FINAL} pass_type;

   // configuration registers
   logic [8:0]  width_ff, height_ff;
   logic [15:0] iter_ff;
   logic [9:0]  interval_ff;
   logic [23:0] thr_ff;

   // sequencer registers
   state_type            state_ff, state_in;
   pass_type             pass_ff, pass_in;
   logic [2:0]           ph_ff, ph_in;
   logic [WW-1:0]        col_ff, col_in;
   logic [HW-1:0]        row_ff, row_in;
   logic [AW-1:0]        addr_ff, addr_in;
   logic [9:0]           grp_ff, grp_in;
   logic [SWEEP_BITS-1:0] done_ff, done_in;
   logic                 conv_ff, conv_in;
   logic                 in_range_ff, in_range_in;
   logic [ERR_BITS-1:0]  err_ff [3];
   logic [ERR_BITS-1:0]  err_in [3];
   logic [TW-1:0]        thr_acc_ff, thr_acc_in;
   logic [CW-1:0]        tot_ff, tot_in, thr3_ff, thr3_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [RSP_DAT_BITS-1:0] rsp_data_ff, rsp_data_in;

   // datapath signals
   logic [WW-1:0]        w_eff;
   logic [HW-1:0]        h_eff;
   logic [AW-1:0]        wa, idx_addr, rd_addr;
   logic                 idx_ok, interior, accept, last_col, last_row;
   logic [1:0]           opcode;
   logic [3*VB-1:0]      ld_tgt, ld_grad, rd_val, rd_grad, upd;
   logic [3*RW-1:0]      res;
   logic                 rd_mask, tgt_we, aux_we;
   logic [9:0]           interval;
   alu_ctl_type          alu_ctl;
   logic [7:0]           pix [3];

   function automatic logic [VB-1:0] sat_in(input logic [FIELD_BITS-1:0] x);
      logic signed [32:0] e;
      e = 33'($signed(x));
      if (e > VMAX) begin
         return VMAX[VB-1:0];
      end else if (e < VMIN) begin
         return VMIN[VB-1:0];
      end
      return e[VB-1:0];
   endfunction

   function automatic logic [ERR_BITS-1:0] sat_add(input logic [ERR_BITS-1:0] a,
                                                   input logic [RW-1:0] b);
      logic [ERR_BITS:0] s;
      s = {1'b0, a} + (ERR_BITS+1)'(b);
      return s[ERR_BITS] ? ERR_MAX : s[ERR_BITS-1:0];
   endfunction

   // clamp image size
   always_comb begin
      if (width_ff == 9'd0) begin
         w_eff = WW'(1);
      end else if (32'(width_ff) > MAX_WIDTH) begin
         w_eff = WW'(MAX_WIDTH);
      end else begin
         w_eff = WW'(width_ff);
      end
      if (height_ff == 9'd0) begin
         h_eff = HW'(1);
      end else if (32'(height_ff) > MAX_HEIGHT) begin
         h_eff = HW'(MAX_HEIGHT);
      end else begin
         h_eff = HW'(height_ff);
      end
   end

   assign wa       = AW'(w_eff);
   assign interior = (w_eff >= WW'(3)) && (h_eff >= HW'(3));
   assign last_col = (col_ff == w_eff - WW'(2));
   assign last_row = (row_ff == h_eff - HW'(2));
   assign interval = (interval_ff == 10'd0) ? 10'd1 : interval_ff;
   assign opcode   = req_tuser;
   assign idx_addr = AW'(req_tdata[15:0]);
   assign idx_ok   = 32'(req_tdata[15:0]) < (32'(w_eff) * 32'(h_eff));
   assign accept   = req_tvalid && req_tready;

   assign req_tready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // saturate incoming pixel terms
   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         ld_tgt[ch*VB +: VB]  = sat_in(req_tdata[17 + ch*FIELD_BITS +: FIELD_BITS]);
         ld_grad[ch*VB +: VB] = sat_in(req_tdata[89 + ch*FIELD_BITS +: FIELD_BITS]);
      end
   end

   // pick the stencil read address
   always_comb begin
      if (state_ff == ST_PIX) begin
         case (ph_ff)
            3'd0:    rd_addr = addr_ff;
            3'd1:    rd_addr = addr_ff - wa;
            3'd2:    rd_addr = addr_ff - AW'(1);
            3'd3:    rd_addr = addr_ff + AW'(1);
            3'd4:    rd_addr = addr_ff + wa;
            default: rd_addr = addr_ff;
         endcase
      end else begin
         rd_addr = idx_addr;
      end
   end

   assign alu_ctl.load_ctr = (state_ff == ST_PIX) && (ph_ff == 3'd1);
   assign alu_ctl.add_nb   = (state_ff == ST_PIX) && (ph_ff >= 3'd2) && (ph_ff <= 3'd5);

   assign aux_we = accept && (opcode == OP_LOAD) && idx_ok;
   assign tgt_we = aux_we ||
                   ((state_ff == ST_PIX) && (ph_ff == 3'd6) && (pass_ff == PASS_SWEEP));

   mprs_store #(.AW(AW), .VB(VB)) u_store (
      .clock   (clock),
      .tgt_we  (tgt_we),
      .aux_we  (aux_we),
      .wr_addr ((state_ff == ST_IDLE) ? idx_addr : addr_ff),
      .wr_tgt  ((state_ff == ST_IDLE) ? ld_tgt : upd),
      .wr_grad (ld_grad),
      .wr_mask (req_tdata[16]),
      .rd_addr (rd_addr),
      .rd_val  (rd_val),
      .rd_grad (rd_grad),
      .rd_mask (rd_mask)
   );

   mprs_alu #(.VB(VB)) u_alu (
      .clock  (clock),
      .ctl    (alu_ctl),
      .rd_val (rd_val),
      .rd_grad(rd_grad),
      .upd    (upd),
      .res    (res)
   );

   // clamp read value to a byte
   always_comb begin
      logic [VB-1:0] v, sh;
      for (int ch = 0; ch < 3; ch++) begin
         v  = rd_val[ch*VB +: VB];
         sh = v >> 8;
         if (v[VB-1] || !in_range_ff) begin
            pix[ch] = 8'd0;
         end else if (sh > VB'(255)) begin
            pix[ch] = 8'd255;
         end else begin
            pix[ch] = sh[7:0];
         end
      end
   end

   // sequencer next state
   always_comb begin
      logic adv;
      state_in     = state_ff;
      pass_in      = pass_ff;
      ph_in        = ph_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      addr_in      = addr_ff;
      grp_in       = grp_ff;
      done_in      = done_ff;
      conv_in      = conv_ff;
      in_range_in  = in_range_ff;
      err_in       = err_ff;
      thr_acc_in   = thr_acc_ff;
      tot_in       = tot_ff;
      thr3_in      = thr3_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      adv          = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               in_range_in = idx_ok;
               case (opcode)
                  OP_READ: state_in = ST_READ;
                  OP_RUN: begin
                     done_in  = '0;
                     conv_in  = 1'b0;
                     state_in = ST_RUN_CHECK;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                     rsp_data_in  = '0;
                  end
               endcase
            end
         end
         ST_READ: begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = {168'd0, pix[2], pix[1], pix[0]};
            state_in     = ST_IDLE;
         end
         ST_RUN_CHECK: begin
            if ((done_ff < SWEEP_BITS'(iter_ff)) && !conv_ff) begin
               grp_in  = '0;
               pass_in = PASS_SWEEP;
            end else begin
               pass_in = PASS_FINAL;
            end
            state_in = ST_PASS_START;
         end
         ST_PASS_START: begin
            err_in     = '{default: '0};
            thr_acc_in = '0;
            row_in     = HW'(1);
            col_in     = WW'(1);
            addr_in    = wa + AW'(1);
            ph_in      = 3'd0;
            state_in   = interior ? ST_PIX : ST_PASS_END;
         end
         ST_PIX: begin
            ph_in = ph_ff + 3'd1;
            if (ph_ff == 3'd1 && !rd_mask) begin
               adv = 1'b1;
            end
            if (ph_ff == 3'd6) begin
               adv = 1'b1;
               if (pass_ff != PASS_SWEEP) begin
                  for (int ch = 0; ch < 3; ch++) begin
                     err_in[ch] = sat_add(err_ff[ch], res[ch*RW +: RW]);
                  end
                  thr_acc_in = thr_acc_ff + TW'(thr_ff);
               end
            end
            // step to the next interior pixel
            if (adv) begin
               ph_in = 3'd0;
               if (last_col) begin
                  if (last_row) begin
                     state_in = ST_PASS_END;
                  end else begin
                     row_in  = row_ff + HW'(1);
                     col_in  = WW'(1);
                     addr_in = addr_ff + AW'(3);
                  end
               end else begin
                  col_in  = col_ff + WW'(1);
                  addr_in = addr_ff + AW'(1);
               end
            end
         end
         ST_PASS_END: begin
            case (pass_ff)
               PASS_SWEEP: begin
                  if ((11'(grp_ff) + 11'd1) < 11'(interval)) begin
                     grp_in   = grp_ff + 10'd1;
                     state_in = ST_PASS_START;
                  end else begin
                     done_in = done_ff + SWEEP_BITS'(interval);
                     if (thr_ff != 24'd0) begin
                        pass_in  = PASS_CHECK;
                        state_in = ST_PASS_START;
                     end else begin
                        state_in = ST_RUN_CHECK;
                     end
                  end
               end
               PASS_CHECK: state_in = ST_CMP_SUM;
               default:    state_in = ST_OUT;
            endcase
         end
         ST_CMP_SUM: begin
            tot_in   = CW'(err_ff[0]) + CW'(err_ff[1]) + CW'(err_ff[2]);
            thr3_in  = (CW'(thr_acc_ff) << 1) + CW'(thr_acc_ff);
            state_in = ST_CMP_TEST;
         end
         ST_CMP_TEST: begin
            conv_in  = tot_ff < thr3_ff;
            state_in = ST_RUN_CHECK;
         end
         ST_OUT: begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = {6'd0, done_ff, conv_ff, err_ff[2], err_ff[1], err_ff[0], 24'd0};
            state_in     = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // hold state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pass_ff      <= PASS_SWEEP;
         ph_ff        <= 3'd0;
         rsp_valid_ff <= 1'b0;
         conv_ff      <= 1'b0;
         done_ff      <= '0;
         width_ff     <= 9'd256;
         height_ff    <= 9'd256;
         iter_ff      <= 16'd0;
         interval_ff  <= 10'd1;
         thr_ff       <= 24'd0;
      end else begin
         state_ff     <= state_in;
         pass_ff      <= pass_in;
         ph_ff        <= ph_in;
         rsp_valid_ff <= rsp_valid_in;
         conv_ff      <= conv_in;
         done_ff      <= done_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_WIDTH:     width_ff    <= csr_data[8:0];
               CSR_HEIGHT:    height_ff   <= csr_data[8:0];
               CSR_ITER:      iter_ff     <= csr_data[15:0];
               CSR_INTERVAL:  interval_ff <= csr_data[9:0];
               CSR_THRESHOLD: thr_ff      <= csr_data[23:0];
               default: ;
            endcase
         end
      end
      col_ff      <= col_in;
      row_ff      <= row_in;
      addr_ff     <= addr_in;
      grp_ff      <= grp_in;
      in_range_ff <= in_range_in;
      err_ff      <= err_in;
      thr_acc_ff  <= thr_acc_in;
      tot_ff      <= tot_in;
      thr3_ff     <= thr3_in;
      rsp_data_ff <= rsp_data_in;
   end

   // walk stays inside the interior
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PIX) |-> (col_ff >= WW'(1)) && (col_ff <= w_eff - WW'(2)))
      else $error("column left the interior");

   // running address matches row and column
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PIX) |->
         (32'(addr_ff) == 32'(row_ff) * 32'(w_eff) + 32'(col_ff)))
      else $error("pixel address out of step");

   // early stop only with a threshold set
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff[168]) |-> (thr_ff != 24'd0))
      else $error("converged without threshold");

endmodule

// ----- dv/tb_masked_poisson_relaxation_solver_core.sv -----
// Self-checking testbench of the masked Poisson relaxation solver core.
`timescale 1ns / 1ps
module tb_masked_poisson_relaxation_solver_core;
   import mprs_pkg::*;

   localparam int  ITEM_TARGET = 1850;
   localparam int  CYCLE_LIMIT = 4000000;
   localparam int  STORE_DEPTH = 65536;
   localparam logic [1:0] OP_NOP = 2'd3;

   // request fields, pixel_index in the lowest bits
   typedef struct packed {
      logic [6:0]  pad;
      logic [23:0] grad_b, grad_g, grad_r;
      logic [23:0] tgt_b, tgt_g, tgt_r;
      logic        mask;
      logic [15:0] idx;
   } pixel_req_type;

   // result fields, pixel_r in the lowest bits
   typedef struct packed {
      logic [5:0]  pad;
      logic [16:0] sweeps;
      logic        conv;
      logic [47:0] err_b, err_g, err_r;
      logic [7:0]  pix_b, pix_g, pix_r;
   } solver_rsp_type;

   typedef struct {
      logic [1:0]     op;
      pixel_req_type  rq;
      bit             typed;
      solver_rsp_type want;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0, req_tready;
   logic [REQ_DAT_BITS-1:0] req_tdata = '0;
   logic [1:0] req_tuser = OP_NOP;
   logic rsp_tvalid, rsp_tready = 1'b0;
   logic [RSP_DAT_BITS-1:0] rsp_tdata;
   logic csr_valid = 1'b0, csr_ready;
   logic [CSR_IDX_BITS-1:0] csr_index = '0;
   logic [CSR_DAT_BITS-1:0] csr_data = '0;

   masked_poisson_relaxation_solver_core u_top (.*);

   always #2 clock = ~clock;

   // shadow of the image and the registers
   longint      tgt_mem[STORE_DEPTH][3];
   longint      grd_mem[STORE_DEPTH][3];
   bit          msk_mem[STORE_DEPTH];
   int unsigned cfg_width = 256, cfg_height = 256, cfg_iter = 0, cfg_intv = 1, cfg_thr = 0;

   solver_rsp_type expected_q[$];
   int  mismatches = 0;
   int  items_sent = 0;
   int  cycles = 0;
   bit  burst_mode = 0;
   bit  hold_req = 0;

   task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
      $display("[%0t] mismatch %s: got 0x%0h want 0x%0h", $realtime, what, got, want);
      mismatches++;
   endtask

   function automatic longint sat_value(longint v);
      return v > 64'sd8388607 ? 64'sd8388607 : (v < -64'sd8388608 ? -64'sd8388608 : v);
   endfunction

   function automatic int eff_dim(int unsigned v);
      return v < 1 ? 1 : (v > 256 ? 256 : v);
   endfunction

   function automatic longint stencil(int id, int w, int ch);
      return grd_mem[id][ch] + tgt_mem[id-w][ch] + tgt_mem[id-1][ch] +
             tgt_mem[id+1][ch] + tgt_mem[id+w][ch];
   endfunction

   // one in-place relaxation pass over the masked interior
   function automatic void relax_sweep(int w, int h);
      int id;
      for (int r = 1; r + 1 < h; r++)
         for (int c = 1; c + 1 < w; c++) begin
            id = r * w + c;
            if (msk_mem[id])
               for (int ch = 0; ch < 3; ch++)
                  tgt_mem[id][ch] = sat_value(stencil(id, w, ch) >>> 2);
         end
   endfunction

   // residual sums per channel; returns the masked interior count
   function automatic longint unsigned residual_sums(int w, int h,
                                                     output longint unsigned s[3]);
      longint unsigned cnt;
      longint d;
      int id;
      cnt = 0;
      s = '{0, 0, 0};
      for (int r = 1; r + 1 < h; r++)
         for (int c = 1; c + 1 < w; c++) begin
            id = r * w + c;
            if (msk_mem[id]) begin
               cnt++;
               for (int ch = 0; ch < 3; ch++) begin
                  d = stencil(id, w, ch) - 4 * tgt_mem[id][ch];
                  s[ch] += d < 0 ? -d : d;
               end
            end
         end
      return cnt;
   endfunction

   function automatic logic [7:0] to_byte(longint v);
      if (v < 0) return 8'd0;
      v = v / 256;
      return v > 255 ? 8'd255 : v[7:0];
   endfunction

   function automatic solver_rsp_type predict_item(logic [1:0] op, pixel_req_type rq);
      solver_rsp_type res;
      int w, h, intv, done;
      bit conv;
      longint unsigned sums[3], cnt;
      longint unsigned errs[3];
      res = '0;
      w = eff_dim(cfg_width);
      h = eff_dim(cfg_height);
      case (op)
         OP_LOAD: begin
            if (rq.idx < w * h) begin
               msk_mem[rq.idx] = rq.mask;
               tgt_mem[rq.idx] = '{longint'(signed'(rq.tgt_r)), longint'(signed'(rq.tgt_g)),
                                   longint'(signed'(rq.tgt_b))};
               grd_mem[rq.idx] = '{longint'(signed'(rq.grad_r)), longint'(signed'(rq.grad_g)),
                                   longint'(signed'(rq.grad_b))};
            end
         end
         OP_READ: begin
            if (rq.idx < w * h) begin
               res.pix_r = to_byte(tgt_mem[rq.idx][0]);
               res.pix_g = to_byte(tgt_mem[rq.idx][1]);
               res.pix_b = to_byte(tgt_mem[rq.idx][2]);
            end
         end
         OP_RUN: begin
            intv = cfg_intv == 0 ? 1 : cfg_intv;
            done = 0;
            conv = 0;
            while (done < cfg_iter && !conv) begin
               repeat (intv) relax_sweep(w, h);
               done += intv;
               if (cfg_thr != 0) begin
                  cnt = residual_sums(w, h, sums);
                  if (cnt > 0 && sums[0] + sums[1] + sums[2] <
                      longint'(cfg_thr) * 3 * cnt)
                     conv = 1;
               end
            end
            void'(residual_sums(w, h, sums));
            foreach (errs[ch]) errs[ch] = sums[ch] > 64'hFFFF_FFFF_FFFF ?
                                          64'hFFFF_FFFF_FFFF : sums[ch];
            res.err_r  = errs[0][47:0];
            res.err_g  = errs[1][47:0];
            res.err_b  = errs[2][47:0];
            res.conv   = conv;
            res.sweeps = done[16:0];
         end
         default: ;
      endcase
      return res;
   endfunction

   // mostly short gaps, a few long ones
   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (burst_mode || r < 45) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // offer one beat and hold valid high afterwards; a gap before the next beat or a settle drops it
   task automatic send_item(input logic [1:0] op, input pixel_req_type rq,
                            input bit typed, input solver_rsp_type typed_rsp);
      int gap;
      solver_rsp_type want;
      gap = idle_len();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= rq;
      do @(posedge clock); while (!req_tready);
      want = predict_item(op, rq);
      expected_q.push_back(typed ? typed_rsp : want);
      items_sent++;
   endtask

   task automatic csr_write(input logic [2:0] idx, input int unsigned val);
      int unsigned bits;
      case (idx)
         CSR_WIDTH, CSR_HEIGHT: bits = 9;
         CSR_ITER:              bits = 16;
         CSR_INTERVAL:          bits = 10;
         default:               bits = 24;
      endcase
      val = val & ((1 << bits) - 1);
      csr_valid <= 1'b1;
      csr_index <= idx;
      // junk above the register width must be dropped
      csr_data  <= 24'(val | ($urandom << bits));
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_WIDTH:     cfg_width  = val;
         CSR_HEIGHT:    cfg_height = val;
         CSR_ITER:      cfg_iter   = val;
         CSR_INTERVAL:  cfg_intv   = val;
         CSR_THRESHOLD: cfg_thr    = val;
         default: ;
      endcase
   endtask

   task automatic configure(int unsigned w, int unsigned h, int unsigned it,
                            int unsigned iv, int unsigned th);
      csr_write(CSR_WIDTH, w);
      csr_write(CSR_HEIGHT, h);
      csr_write(CSR_ITER, it);
      csr_write(CSR_INTERVAL, iv);
      csr_write(CSR_THRESHOLD, th);
      csr_valid <= 1'b0;
   endtask

   // drain every pending result, then leave room for the block to go idle
   task automatic settle();
      req_tvalid <= 1'b0;
      wait (expected_q.size() == 0);
      repeat (20) @(posedge clock);
   endtask

   function automatic logic [23:0] rand_value();
      case ($urandom_range(0, 9))
         0:       return 24'h7FFFFF;
         1:       return 24'h800000;
         2, 3:    return 24'($urandom);
         default: return 24'($urandom_range(0, 153600) - 76800);
      endcase
   endfunction

   function automatic pixel_req_type rand_pixel(int idx, bit force_mask);
      pixel_req_type rq;
      rq = '0;
      rq.idx    = 16'(idx);
      rq.mask   = force_mask | ($urandom_range(0, 9) < 6);
      rq.tgt_r  = rand_value();
      rq.tgt_g  = rand_value();
      rq.tgt_b  = rand_value();
      rq.grad_r = rand_value();
      rq.grad_g = rand_value();
      rq.grad_b = rand_value();
      return rq;
   endfunction

   // response side: random stalls, one long hold-off on request
   initial begin : rsp_stall
      int n;
      wait (!reset);
      forever begin
         n = hold_req ? 400 : idle_len();
         hold_req = 0;
         if (n > 0) begin
            rsp_tready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 20)) @(posedge clock);
      end
   end

   // compare every result beat with the oldest expectation
   always @(posedge clock) begin
      solver_rsp_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (expected_q.size() == 0) begin
            report_mismatch("unexpected beat", got.sweeps, 0);
         end else begin
            want = expected_q.pop_front();
            if (got.pix_r  !== want.pix_r)  report_mismatch("pixel_r", got.pix_r, want.pix_r);
            if (got.pix_g  !== want.pix_g)  report_mismatch("pixel_g", got.pix_g, want.pix_g);
            if (got.pix_b  !== want.pix_b)  report_mismatch("pixel_b", got.pix_b, want.pix_b);
            if (got.err_r  !== want.err_r)  report_mismatch("error_r", got.err_r, want.err_r);
            if (got.err_g  !== want.err_g)  report_mismatch("error_g", got.err_g, want.err_g);
            if (got.err_b  !== want.err_b)  report_mismatch("error_b", got.err_b, want.err_b);
            if (got.conv   !== want.conv)   report_mismatch("converged", got.conv, want.conv);
            if (got.sweeps !== want.sweeps) report_mismatch("sweeps_done", got.sweeps,
                                                            want.sweeps);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin : stimulus
      stim_row_type   table_rows[$];
      stim_row_type   row;
      pixel_req_type  rq;
      solver_rsp_type zero_rsp;
      int w, h, n, phase, pick;
      bit all_mask;
      zero_rsp = '0;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part on a 4x4 image with two sweeps
      configure(4, 4, 2, 1, 0);
      for (int i = 0; i < 16; i++) begin
         row = '{op: OP_LOAD, rq: rand_pixel(i, 0), typed: 1, want: zero_rsp};
         if (i == 0) begin
            row.rq.tgt_r = 24'h7FFFFF;
            row.rq.tgt_g = 24'h800000;
            row.rq.tgt_b = 24'h000180;
         end
         // a masked border pixel is never updated
         if (i == 3) row.rq.mask = 1'b1;
         if (i == 5) begin
            row.rq.mask   = 1'b1;
            row.rq.grad_r = 24'h7FFFFF;
            row.rq.grad_g = 24'h800000;
         end
         table_rows.push_back(row);
      end
      row = '{op: OP_READ, rq: '0, typed: 1, want: zero_rsp};
      row.want.pix_r = 8'd255;
      row.want.pix_b = 8'd1;
      table_rows.push_back(row);
      // index outside the image: read gives zero, load is dropped
      row = '{op: OP_READ, rq: '0, typed: 1, want: zero_rsp};
      row.rq.idx = 16'd16;
      table_rows.push_back(row);
      row = '{op: OP_LOAD, rq: rand_pixel(16'hFFFF, 1), typed: 1, want: zero_rsp};
      table_rows.push_back(row);
      row = '{op: OP_NOP, rq: rand_pixel(5, 1), typed: 1, want: zero_rsp};
      table_rows.push_back(row);
      row = '{op: OP_RUN, rq: '0, typed: 0, want: zero_rsp};
      table_rows.push_back(row);
      row = '{op: OP_READ, rq: '0, typed: 0, want: zero_rsp};
      row.rq.idx = 16'd5;
      table_rows.push_back(row);
      row.rq.idx = 16'd3;
      table_rows.push_back(row);
      foreach (table_rows[i])
         send_item(table_rows[i].op, table_rows[i].rq, table_rows[i].typed,
                   table_rows[i].want);
      settle();

      // random phases: new settings, fill the image, then mixed traffic
      phase = 0;
      items_sent = 0;
      while (items_sent < ITEM_TARGET) begin
         all_mask = 0;
         case (phase)
            0: configure(256, 3, 1, 1, 0);
            1: begin
               configure(0, 511, 5, 1023, $urandom_range(1, 100));
               hold_req = 1;
            end
            2: begin
               configure(3, 3, 65535, 1023, 24'hFFFFFF);
               all_mask = 1;
            end
            3: configure(511, 1, 0, 0, 0);
            default: configure($urandom_range(1, 8), $urandom_range(1, 8),
                               $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12),
                               $urandom_range(0, 4),
                               $urandom_range(0, 1) ? 0 :
                               ($urandom_range(0, 4) == 0 ? $urandom :
                                $urandom_range(1, 2000)));
         endcase
         burst_mode = ($urandom_range(0, 3) == 0);
         w = eff_dim(cfg_width);
         h = eff_dim(cfg_height);
         for (int i = 0; i < w * h; i++)
            send_item(OP_LOAD, rand_pixel(i, all_mask), 0, zero_rsp);
         n = $urandom_range(30, 80);
         repeat (n) begin
            pick = $urandom_range(0, 99);
            if (pick < 65) begin
               rq = rand_pixel($urandom_range(0, 9) == 0 ? $urandom_range(w * h, 65535) :
                               $urandom_range(0, w * h - 1), all_mask);
               send_item(OP_LOAD, rq, 0, zero_rsp);
            end else if (pick < 88) begin
               rq = rand_pixel($urandom_range(0, 6) == 0 ? $urandom_range(w * h, 65535) :
                               $urandom_range(0, w * h - 1), 0);
               send_item(OP_READ, rq, 0, zero_rsp);
            end else if (pick < 96) begin
               send_item(OP_RUN, rand_pixel($urandom, 0), 0, zero_rsp);
            end else begin
               send_item(OP_NOP, rand_pixel($urandom, 0), 0, zero_rsp);
            end
         end
         send_item(OP_RUN, rand_pixel(0, 0), 0, zero_rsp);
         settle();
         phase++;
      end

      repeat (50) @(posedge clock);
      if (mismatches == 0 && expected_q.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
